/* sv/pal_pkg.sv */
// Package for the positional array list core: operation and status codes,
// field widths and the default list depth.
// Depends on nothing; the files that use it take its names by scope.
`default_nettype none

package pal_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* sv/pal_req_if.sv */
// Request channel of the positional array list core: valid/ready handshake
// with the opcode, position and value fields. Depends on pal_pkg.
`default_nettype none

interface pal_req_if;

    logic                               valid;
    logic                               ready;
    logic [pal_pkg::OP_W-1:0]           opcode;
    logic [pal_pkg::POS_W-1:0]          position;
    logic signed [pal_pkg::DATA_W-1:0]  value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);

endinterface

`default_nettype wire

/* sv/pal_rsp_if.sv */
// Response channel of the positional array list core: valid/ready handshake
// with status, read data, found position and length. Depends on pal_pkg.
`default_nettype none

interface pal_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [pal_pkg::ST_W-1:0]           status;
    logic signed [pal_pkg::DATA_W-1:0]  read_data;
    logic [pal_pkg::POS_W-1:0]          found_position;
    logic [pal_pkg::POS_W-1:0]          length;

    modport source (output valid, output status, output read_data, output found_position,
                    output length, input ready);
    modport sink   (input valid, input status, input read_data, input found_position,
                    input length, output ready);

endinterface

`default_nettype wire

/* sv/pal_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/positional_array_list_core.sv */
// Positional array list core: an ordered list of up to DEPTH signed 32-bit
// words in one RAM, with insert, delete, read and find by one-based position.
// Depends on pal_pkg, pal_req_if, pal_rsp_if and pal_ram.
`default_nettype none

// The list lives in a single RAM with one read and one write port, and a
// small sequencer moves entries one at a time: each entry that an insert or
// delete shifts, and each entry that a find compares, takes a read step
// (S_RD) and then a write or compare step (S_XFER). A rejected request
// (full list or bad position) goes straight to the finishing step, which
// waits while the response register still holds a beat not yet taken. The
// block takes one request at a time and drops ready until the result is
// loaded into the response register; that register holds a finished beat
// while the next request is already being worked on. Positions are 5 bits
// wide, so with DEPTH above 31 the upper places cannot be addressed, and
// length and found_position keep their low 5 bits. After reset the list is
// empty; entries are only read once written.

module positional_array_list_core #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pal_req_if.sink    req,
    pal_rsp_if.source  rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_XFER = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Sequencer and list state
    state_t                      state_reg, state_next;
    pal_pkg::opcode_t            op_reg, op_next;
    logic [pal_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [pal_pkg::DATA_W-1:0]  value_reg, value_next;
    logic [CW-1:0]               cur_reg, cur_next;
    logic [CW-1:0]               count_reg, count_next;

    // Result staged until the response register is free
    pal_pkg::status_t            res_status_reg, res_status_next;
    logic [pal_pkg::DATA_W-1:0]  res_data_reg, res_data_next;
    logic [CW-1:0]               res_fpos_reg, res_fpos_next;

    // Response register
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [pal_pkg::ST_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [pal_pkg::DATA_W-1:0]  rsp_data_reg, rsp_data_next;
    logic [pal_pkg::POS_W-1:0]   rsp_fpos_reg, rsp_fpos_next;
    logic [pal_pkg::POS_W-1:0]   rsp_len_reg, rsp_len_next;

    // RAM port controls
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [pal_pkg::DATA_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [pal_pkg::DATA_W-1:0]  rd_data;

    // Widened copies for range compares
    logic [CMPW-1:0]             in_pos_ext;
    logic [CMPW-1:0]             in_pos_m1;
    logic [CMPW-1:0]             pos_ext;
    logic [CMPW-1:0]             cnt_ext;
    logic [CMPW-1:0]             cur_ext;
    logic [CMPW-1:0]             fpos_ext;
    logic [CW-1:0]               cur_m1;
    logic [CW-1:0]               cur_p1;

    assign in_pos_ext = CMPW'(req.position);
    assign in_pos_m1  = in_pos_ext - CMPW'(1);
    assign pos_ext    = CMPW'(pos_reg);
    assign cnt_ext    = CMPW'(count_reg);
    assign cur_ext    = CMPW'(cur_reg);
    assign fpos_ext   = CMPW'(res_fpos_reg);
    assign cur_m1     = cur_reg - CW'(1);
    assign cur_p1     = cur_reg + CW'(1);

    pal_ram #(
        .WIDTH (pal_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_fpos_next   = res_fpos_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_fpos_next   = rsp_fpos_reg;
        rsp_len_next    = rsp_len_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg[AW-1:0];
        wr_data         = value_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = pal_pkg::opcode_t'(req.opcode);
                    pos_next        = req.position;
                    value_next      = req.value;
                    res_status_next = pal_pkg::ST_OK;
                    res_data_next   = '0;
                    res_fpos_next   = '0;
                    state_next      = S_RD;
                    case (pal_pkg::opcode_t'(req.opcode))
                        pal_pkg::OP_INSERT:
                        begin
                            cur_next = count_reg;
                            if (cnt_ext >= CMPW'(DEPTH))
                            begin
                                res_status_next = pal_pkg::ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (in_pos_ext == '0 || in_pos_ext > cnt_ext + CMPW'(1))
                            begin
                                res_status_next = pal_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        pal_pkg::OP_DELETE:
                        begin
                            cur_next = in_pos_ext[CW-1:0];
                            if (in_pos_ext == '0 || in_pos_ext > cnt_ext)
                            begin
                                res_status_next = pal_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        pal_pkg::OP_READ:
                        begin
                            cur_next = in_pos_m1[CW-1:0];
                            if (in_pos_ext == '0 || in_pos_ext > cnt_ext)
                            begin
                                res_status_next = pal_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        pal_pkg::OP_FIND:
                        begin
                            cur_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                case (op_reg)
                    pal_pkg::OP_INSERT:
                    begin
                        // Gap reached: drop the new word in and grow the list
                        if (cur_ext < pos_ext)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = cur_reg[AW-1:0];
                            wr_data    = value_reg;
                            count_next = count_reg + CW'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_m1[AW-1:0];
                            state_next = S_XFER;
                        end
                    end
                    pal_pkg::OP_DELETE:
                    begin
                        if (cur_reg >= count_reg)
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_reg[AW-1:0];
                            state_next = S_XFER;
                        end
                    end
                    pal_pkg::OP_READ:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_reg[AW-1:0];
                        state_next = S_XFER;
                    end
                    pal_pkg::OP_FIND:
                    begin
                        if (cur_reg >= count_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_reg[AW-1:0];
                            state_next = S_XFER;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_XFER:
            begin
                case (op_reg)
                    pal_pkg::OP_INSERT:
                    begin
                        // Shift one entry up and step toward the insert point
                        wr_en      = 1'b1;
                        wr_addr    = cur_reg[AW-1:0];
                        wr_data    = rd_data;
                        cur_next   = cur_m1;
                        state_next = S_RD;
                    end
                    pal_pkg::OP_DELETE:
                    begin
                        // Shift one entry down and advance toward the tail
                        wr_en      = 1'b1;
                        wr_addr    = cur_m1[AW-1:0];
                        wr_data    = rd_data;
                        cur_next   = cur_p1;
                        state_next = S_RD;
                    end
                    pal_pkg::OP_READ:
                    begin
                        res_data_next = rd_data;
                        state_next    = S_DONE;
                    end
                    pal_pkg::OP_FIND:
                    begin
                        if (rd_data == value_reg)
                        begin
                            res_fpos_next = cur_p1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cur_next   = cur_p1;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                // Hold the result until the response register can take it
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_data_next   = res_data_reg;
                    rsp_fpos_next   = fpos_ext[pal_pkg::POS_W-1:0];
                    rsp_len_next    = cnt_ext[pal_pkg::POS_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_fpos_reg   <= res_fpos_next;
        rsp_status_reg <= rsp_status_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_fpos_reg   <= rsp_fpos_next;
        rsp_len_reg    <= rsp_len_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.read_data      = rsp_data_reg;
    assign rsp.found_position = rsp_fpos_reg;
    assign rsp.length         = rsp_len_reg;

    // The list never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= CMPW'(DEPTH))
        else $error("list count exceeds depth");

    // The count only moves at the end of an insert or delete
    a_count_moves_in_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_RD))
        else $error("list count changed outside the final step");

    // A rejected request leaves the count alone
    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg != pal_pkg::ST_OK) |-> $stable(count_reg))
        else $error("rejected request changed the list count");

    // A new response beat is loaded only from the finishing step
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (!$past(rsp_valid_reg) || $past(rsp.ready)))
        |-> ($past(state_reg) == S_DONE))
        else $error("response loaded outside the finishing step");

    // A find hit lies within the entries in use
    a_find_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg == pal_pkg::OP_FIND && res_fpos_reg != '0)
        |-> (res_fpos_reg <= count_reg))
        else $error("find position beyond list length");

endmodule

`default_nettype wire
